@@ design/rsm_pkg.sv @@
// Shared types and constants of the ray sphere march shader.
package rsm_pkg;

  localparam int CFG_IDX_W = 2;
  localparam logic signed [20:0] DEPTH_LIMIT = 21'sd1600;
  localparam logic signed [20:0] DEPTH_STEP = 21'sd16;
  localparam logic [7:0] SHADE_MAX = 8'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPHERE_COUNT = 2'd0,
    CFG_BRIGHTNESS   = 2'd1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MARCH,
    ST_SHADE,
    ST_DONE
  } top_state_t;

  typedef enum logic [1:0] {
    SH_IDLE,
    SH_MUL,
    SH_CHK,
    SH_DIV
  } shd_state_t;

  // ray sample travelling down the sphere chain
  typedef struct packed {
    logic        valid;
    logic [19:0] x;
    logic [19:0] y;
    logic [20:0] z;
    logic        found;
    logic [23:0] col;
  } tok_t;

  // sphere table write broadcast to every cell
  typedef struct packed {
    logic        en;
    logic [5:0]  idx;
    logic [19:0] x;
    logic [19:0] y;
    logic [19:0] z;
    logic [17:0] radius;
    logic [23:0] col;
  } wr_t;

endpackage

@@ design/rsm_cell.sv @@
// One sphere cell: holds one table entry and tests passing ray samples against it.
module rsm_cell #(
  parameter int IDX = 0,
  parameter int IW  = 6
) (
  input  logic          clk,
  input  logic          rst_n,
  input  rsm_pkg::wr_t  wr_i,
  input  logic [6:0]    count_i,
  input  rsm_pkg::tok_t tok_i,
  input  logic [IW-1:0] who_i,
  output rsm_pkg::tok_t tok_o,
  output logic [IW-1:0] who_o
);
  import rsm_pkg::*;

  logic signed [19:0] cx_r, cy_r, cz_r;
  logic [35:0]        rr_r;
  logic [23:0]        col_r;
  tok_t               s1_tok_r, s2_tok_r;
  logic [IW-1:0]      s1_who_r, s2_who_r;
  logic               s1_act_r;
  logic [43:0]        sqx_r, sqy_r, sqz_r;
  logic signed [21:0] dx, dy, dz;
  logic [45:0]        dist_sq;
  logic               hit;

  assign dx = 22'(signed'(tok_i.x)) - 22'(cx_r);
  assign dy = 22'(signed'(tok_i.y)) - 22'(cy_r);
  assign dz = 22'(signed'(tok_i.z)) - 22'(cz_r);
  assign dist_sq = 46'(sqx_r) + 46'(sqy_r) + 46'(sqz_r);
  assign hit = s1_tok_r.valid & s1_act_r & ~s1_tok_r.found & (dist_sq <= 46'(rr_r));

  always_ff @(posedge clk) begin
    if (wr_i.en && (32'(wr_i.idx) == IDX)) begin
      cx_r  <= signed'(wr_i.x);
      cy_r  <= signed'(wr_i.y);
      cz_r  <= signed'(wr_i.z);
      rr_r  <= 36'(wr_i.radius) * 36'(wr_i.radius);
      col_r <= wr_i.col;
    end
  end

  // squares first, then sum and compare
  always_ff @(posedge clk) begin
    sqx_r    <= 44'(dx * dx);
    sqy_r    <= 44'(dy * dy);
    sqz_r    <= 44'(dz * dz);
    s1_act_r <= (32'(count_i) > IDX);
    s1_who_r <= who_i;
    if (!rst_n) begin
      s1_tok_r.valid <= 1'b0;
    end else begin
      s1_tok_r <= tok_i;
    end
  end

  always_ff @(posedge clk) begin
    s2_who_r <= hit ? IW'(IDX) : s1_who_r;
    if (!rst_n) begin
      s2_tok_r.valid <= 1'b0;
    end else begin
      s2_tok_r <= s1_tok_r;
      if (hit) begin
        s2_tok_r.found <= 1'b1;
        s2_tok_r.col   <= col_r;
      end
    end
  end

  assign tok_o = s2_tok_r;
  assign who_o = s2_who_r;

endmodule

@@ design/rsm_shade.sv @@
// Shading unit: per channel min(floor(C*K/Z^2),255) by restoring division.
module rsm_shade (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start_i,
  input  logic [23:0] col_i,
  input  logic [31:0] k_i,
  input  logic [20:0] z_i,
  output logic        done_o,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o
);
  import rsm_pkg::*;

  shd_state_t  st_r, st_nxt;
  logic [1:0]  ch_r;
  logic [2:0]  bit_r;
  logic [23:0] col_r;
  logic [31:0] k_r;
  logic [20:0] z_r;
  logic [41:0] zz_r;
  logic [39:0] num_r, rem_r;
  logic [7:0]  q_r, red_r, green_r, blue_r;
  logic        done_r;
  logic [7:0]  chan;
  logic [49:0] trial;
  logic        ge, over, fin;
  logic [7:0]  q_fin;

  always_comb begin
    unique case (ch_r)
      2'd0:    chan = col_r[23:16];
      2'd1:    chan = col_r[15:8];
      2'd2:    chan = col_r[7:0];
      default: chan = 8'd0;
    endcase
  end

  assign trial = 50'(zz_r) << bit_r;
  assign ge    = 50'(rem_r) >= trial;
  assign over  = 50'(num_r) >= (50'(zz_r) << 8);

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      SH_IDLE: if (start_i) st_nxt = SH_MUL;
      SH_MUL:  st_nxt = SH_CHK;
      SH_CHK: begin
        if (zz_r == '0 || over) st_nxt = (ch_r == 2'd2) ? SH_IDLE : SH_MUL;
        else st_nxt = SH_DIV;
      end
      SH_DIV: begin
        if (bit_r == 3'd0) st_nxt = (ch_r == 2'd2) ? SH_IDLE : SH_MUL;
      end
      default: st_nxt = SH_IDLE;
    endcase
  end

  always_comb begin
    fin   = 1'b0;
    q_fin = 8'd0;
    unique case (st_r)
      SH_CHK: begin
        fin   = (zz_r == '0) || over;
        q_fin = (zz_r == '0 && chan == 8'd0) ? 8'd0 : SHADE_MAX;
      end
      SH_DIV: begin
        fin   = (bit_r == 3'd0);
        q_fin = q_r | (ge ? (8'd1 << bit_r) : 8'd0);
      end
      default: begin
        fin   = 1'b0;
        q_fin = 8'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= SH_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= fin && (ch_r == 2'd2);
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == SH_IDLE && start_i) begin
      col_r <= col_i;
      k_r   <= k_i;
      z_r   <= z_i;
      ch_r  <= 2'd0;
    end
    if (st_r == SH_MUL) begin
      zz_r  <= 42'(signed'(z_r) * signed'(z_r));
      num_r <= 40'(chan) * 40'(k_r);
    end
    if (st_r == SH_CHK) begin
      rem_r <= num_r;
      bit_r <= 3'd7;
      q_r   <= 8'd0;
    end
    if (st_r == SH_DIV) begin
      if (ge) begin
        rem_r <= 40'(50'(rem_r) - trial);
        q_r   <= q_fin;
      end
      bit_r <= bit_r - 3'd1;
    end
    if (fin) begin
      unique case (ch_r)
        2'd0:    red_r <= q_fin;
        2'd1:    green_r <= q_fin;
        default: blue_r <= q_fin;
      endcase
      ch_r <= ch_r + 2'd1;
    end
  end

  assign done_o  = done_r;
  assign red_o   = red_r;
  assign green_o = green_r;
  assign blue_o  = blue_r;

endmodule

@@ design/ray_sphere_march_shader_unit.sv @@
// Top level of the ray sphere march shader: sphere cell chain, march control, shading.
//
// Input channel (in_valid / in_stall): a mode 0 transfer writes sphere entry
// in_entry_index; a mode 1 transfer casts a ray at (in_pos_x, in_pos_y,
// in_pos_z) and yields one result on the out_ channel.
// Configuration (cfg_valid / cfg_ready, always ready): index 0 sphere_count,
// index 1 brightness; write only while the block is idle.
// Every sphere lives in one cell of a row of MAX_SPHERES cells. Ray samples,
// one per depth, enter the row one per cycle and pass each cell through its
// squares stage, then its compare stage; each carries the first sphere it met.
// A ray marches by feeding samples at every depth below the limit (100 from
// depth zero), cut once a hit leaves the row; then, on a hit, the shading
// divider works out 8 quotient bits per channel.
// In_stall stays high from a ray transfer until its result is registered.
// A result held by out_stall blocks only the next ray's result; the next item
// is still taken. Reset clears the control state and the registers to their
// reset values; the sphere table is undefined until written.
module ray_sphere_march_shader_unit #(
  parameter int MAX_SPHERES = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_mode,
  input  logic [5:0]                   in_entry_index,
  input  logic signed [19:0]           in_pos_x,
  input  logic signed [19:0]           in_pos_y,
  input  logic signed [19:0]           in_pos_z,
  input  logic [17:0]                  in_radius,
  input  logic [7:0]                   in_red,
  input  logic [7:0]                   in_green,
  input  logic [7:0]                   in_blue,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [rsm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                  cfg_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_hit,
  output logic [5:0]                   out_hit_index,
  output logic [7:0]                   out_red,
  output logic [7:0]                   out_green,
  output logic [7:0]                   out_blue,
  output logic signed [20:0]           out_end_depth
);
  import rsm_pkg::*;

  localparam int IW = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
  localparam int CW = $clog2(2 * MAX_SPHERES + 2);

  top_state_t  st_r, st_nxt;
  logic [6:0]  count_r;
  logic [31:0] bright_r;
  logic        in_acc, inject, drained, shd_start, load_out;
  wr_t         wr;
  tok_t        chain [MAX_SPHERES+1];
  logic [IW-1:0] who_c [MAX_SPHERES+1];
  tok_t        exit_tok;
  logic [19:0] ray_x_r, ray_y_r;
  logic [20:0] inj_z_r, inj_z_step;
  logic        inj_more_r;
  logic [CW-1:0] inflight_r;
  logic        res_found_r;
  logic [IW-1:0] res_who_r;
  logic [23:0] res_col_r;
  logic [20:0] res_z_r;
  logic        shd_done;
  logic [7:0]  shd_red, shd_green, shd_blue;
  logic        out_valid_r, out_hit_r;
  logic [5:0]  out_idx_r;
  logic [7:0]  out_red_r, out_green_r, out_blue_r;
  logic [20:0] out_z_r;

  // configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= 7'd0;
      bright_r <= 32'd256;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SPHERE_COUNT: count_r <= cfg_data[6:0];
        CFG_BRIGHTNESS:   bright_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_acc = in_valid & ~in_stall;

  // broadcast sphere writes to the row
  assign wr.en     = in_acc & ~in_mode;
  assign wr.idx    = in_entry_index;
  assign wr.x      = in_pos_x;
  assign wr.y      = in_pos_y;
  assign wr.z      = in_pos_z;
  assign wr.radius = in_radius;
  assign wr.col    = {in_red, in_green, in_blue};

  // feed one depth sample per cycle into the head of the row
  assign chain[0].valid = inject;
  assign chain[0].x     = ray_x_r;
  assign chain[0].y     = ray_y_r;
  assign chain[0].z     = inj_z_r;
  assign chain[0].found = 1'b0;
  assign chain[0].col   = 24'd0;
  assign who_c[0]       = '0;

  for (genvar i = 0; i < MAX_SPHERES; i++) begin : g_cell
    rsm_cell #(.IDX(i), .IW(IW)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .wr_i    (wr),
      .count_i (count_r),
      .tok_i   (chain[i]),
      .who_i   (who_c[i]),
      .tok_o   (chain[i+1]),
      .who_o   (who_c[i+1])
    );
  end

  assign exit_tok   = chain[MAX_SPHERES];
  assign inj_z_step = 21'(signed'(inj_z_r) + DEPTH_STEP);
  assign drained    = ~inj_more_r && (inflight_r == '0);

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE:  if (in_acc && in_mode) st_nxt = ST_MARCH;
      ST_MARCH: if (drained) st_nxt = res_found_r ? ST_SHADE : ST_DONE;
      ST_SHADE: if (shd_done) st_nxt = ST_DONE;
      ST_DONE:  if (load_out) st_nxt = ST_IDLE;
      default:  st_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall  = (st_r != ST_IDLE);
    inject    = (st_r == ST_MARCH) && inj_more_r;
    shd_start = (st_r == ST_MARCH) && drained && res_found_r;
    load_out  = (st_r == ST_DONE) && (~out_valid_r || ~out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= ST_IDLE;
      inj_more_r <= 1'b0;
      inflight_r <= '0;
    end else begin
      st_r       <= st_nxt;
      inflight_r <= inflight_r + CW'(inject) - CW'(exit_tok.valid);
      if (in_acc && in_mode) begin
        inj_more_r <= 1'b1;
      end else if (inject) begin
        // drop further depths once past the limit or once a hit came back
        inj_more_r <= (signed'(inj_z_step) < DEPTH_LIMIT) && ~res_found_r &&
                      ~(exit_tok.valid && exit_tok.found);
      end
    end
  end

  // ray capture and result collection; samples leave the row in depth order
  always_ff @(posedge clk) begin
    if (in_acc && in_mode) begin
      ray_x_r     <= in_pos_x;
      ray_y_r     <= in_pos_y;
      inj_z_r     <= 21'(in_pos_z);
      res_found_r <= 1'b0;
    end else begin
      if (inject) inj_z_r <= inj_z_step;
      if (st_r == ST_MARCH && exit_tok.valid && !res_found_r) begin
        if (exit_tok.found) begin
          res_found_r <= 1'b1;
          res_who_r   <= who_c[MAX_SPHERES];
          res_col_r   <= exit_tok.col;
          res_z_r     <= exit_tok.z;
        end else begin
          res_z_r <= 21'(signed'(exit_tok.z) + DEPTH_STEP);
        end
      end
    end
  end

  rsm_shade u_shade (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (shd_start),
    .col_i   (res_col_r),
    .k_i     (bright_r),
    .z_i     (res_z_r),
    .done_o  (shd_done),
    .red_o   (shd_red),
    .green_o (shd_green),
    .blue_o  (shd_blue)
  );

  // output register: hold the result until transferred
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_hit_r   <= res_found_r;
      out_idx_r   <= res_found_r ? 6'(res_who_r) : 6'd0;
      out_red_r   <= res_found_r ? shd_red : 8'd0;
      out_green_r <= res_found_r ? shd_green : 8'd0;
      out_blue_r  <= res_found_r ? shd_blue : 8'd0;
      out_z_r     <= res_z_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_hit       = out_hit_r;
  assign out_hit_index = out_idx_r;
  assign out_red       = out_red_r;
  assign out_green     = out_green_r;
  assign out_blue      = out_blue_r;
  assign out_end_depth = signed'(out_z_r);

endmodule

@@ design/rsm_checker.sv @@
// Port level checks of the ray sphere march shader, bound to the top level.
module rsm_port_checks (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                in_mode,
  input logic                out_valid,
  input logic                out_stall,
  input logic                out_hit,
  input logic [5:0]          out_hit_index,
  input logic [7:0]          out_red,
  input logic [7:0]          out_green,
  input logic [7:0]          out_blue,
  input logic signed [20:0]  out_end_depth
);

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_hit_index) &&
    $stable(out_end_depth))
    else $error("stalled result changed");

  a_miss_black: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_hit_index == 6'd0 && out_red == 8'd0 &&
    out_green == 8'd0 && out_blue == 8'd0)
    else $error("miss result not black");

  a_ray_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_mode |=> in_stall)
    else $error("ray transfer not followed by stall");

endmodule

bind ray_sphere_march_shader_unit rsm_port_checks u_rsm_checker (.*);
